>>> hdl/lkv_pkg.sv
// Shared types and constants for the LRU key/value cache.
package lkv_pkg;

    // Request kinds carried on s_tuser
    typedef enum logic {
        CMD_GET = 1'b0,
        CMD_PUT = 1'b1
    } cmd_t;

    // Capacity register width and its value after reset
    localparam int          CAP_BITS  = 5;
    localparam logic [4:0]  CAP_RESET = 5'd16;

    // Broadcast control from the top level to every cell
    typedef struct packed {
        logic update;   // a request is retired this cycle
        logic clear;    // capacity write: empty the store
        logic hit_any;  // some cell holds the request key
        logic put;      // request is a put
        logic insert;   // put of a new key
        logic full;     // occupancy has reached the capacity
    } cell_ctrl_t;

endpackage

>>> hdl/lkv_cell.sv
// One cache entry: key, data, validity and recency rank, with its update rules.
module lkv_cell #(
    parameter int KEY_BITS  = 32,
    parameter int DATA_BITS = 32,
    parameter int RANK_BITS = 4
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  lkv_pkg::cell_ctrl_t   ctrl,
    input  logic [KEY_BITS-1:0]   req_key,
    input  logic [DATA_BITS-1:0]  req_data,
    input  logic [RANK_BITS-1:0]  hit_rank,
    input  logic [RANK_BITS-1:0]  evict_rank,
    input  logic                  free_in,    // a lower cell already takes the new key
    output logic                  free_out,
    output logic                  match,
    output logic                  take,
    output logic                  valid,
    output logic [RANK_BITS-1:0]  rank,
    output logic [DATA_BITS-1:0]  data
);

    logic                 valid_reg, valid_next;
    logic [KEY_BITS-1:0]  key_reg, key_next;
    logic [DATA_BITS-1:0] data_reg, data_next;
    logic [RANK_BITS-1:0] rank_reg, rank_next;
    logic                 evict;
    logic                 valid_after;

    // Lookup, eviction and free-slot chain
    assign match       = valid_reg && (key_reg == req_key);
    assign evict       = ctrl.insert && ctrl.full && valid_reg && (rank_reg == evict_rank);
    assign valid_after = valid_reg && !evict;
    assign take        = ctrl.insert && !valid_after && !free_in;
    assign free_out    = free_in || !valid_after;

    assign valid = valid_reg;
    assign rank  = rank_reg;
    assign data  = data_reg;

    // Next entry contents
    always_comb begin
        valid_next = valid_reg;
        key_next   = key_reg;
        data_next  = data_reg;
        rank_next  = rank_reg;
        if (ctrl.clear) begin
            valid_next = 1'b0;
        end else if (ctrl.update) begin
            if (ctrl.hit_any) begin
                // promote the hit entry, age the more recent ones
                if (match) begin
                    rank_next = '0;
                    if (ctrl.put) begin
                        data_next = req_data;
                    end
                end else if (valid_reg && (rank_reg < hit_rank)) begin
                    rank_next = rank_reg + 1'b1;
                end
            end else if (ctrl.insert) begin
                if (take) begin
                    valid_next = 1'b1;
                    key_next   = req_key;
                    data_next  = req_data;
                    rank_next  = '0;
                end else begin
                    valid_next = valid_after;
                    if (valid_after) begin
                        rank_next = rank_reg + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg  <= key_next;
        data_reg <= data_next;
        rank_reg <= rank_next;
    end

endmodule

>>> hdl/lru_key_value_cache.sv
// Top level of the LRU key/value cache: request register, row of cells, result register.
//
// Usage:
//   Requests arrive on s_tvalid/s_tready with s_tuser = command (0 get, 1 put)
//   and s_tdata = {value, key}. A get gives one result on m_tvalid/m_tready:
//   m_tuser = hit, m_tdata = stored value, or all ones on a miss. A put gives
//   no result. cfg_wr_en with cfg_wr_data sets the capacity (0 acts as 1, above
//   MAX_ENTRIES acts as MAX_ENTRIES) and empties the cache; write it only idle.
// Timing:
//   A request is held in an input register and retired from it by the
//   row of MAX_ENTRIES cells, which compare the key in parallel and update
//   ranks locally; the free slot is found by a carry that ripples from cell
//   to cell. A get result is loaded into the result register when the get
//   retires. One request per cycle is sustained while the result register drains.
// Reset and stall:
//   Reset empties the cache, sets capacity 16 and drops m_tvalid. While a get
//   result waits on m_tready a following get is held in the input register
//   and s_tready falls; puts still retire.
module lru_key_value_cache #(
    parameter int MAX_ENTRIES = 16,
    parameter int KEY_BITS    = 32,
    parameter int DATA_BITS   = 32
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic [4:0]               cfg_wr_data,  // capacity
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [((KEY_BITS + DATA_BITS + 7) / 8) * 8 - 1:0] s_tdata,  // key, value, zero fill
    input  logic                     s_tuser,      // command
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [((DATA_BITS + 7) / 8) * 8 - 1:0] m_tdata,  // read_value, zero fill
    output logic                     m_tuser       // hit
);

    localparam int M_TDATA_BITS = ((DATA_BITS + 7) / 8) * 8;
    localparam int RANK_BITS    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_BITS     = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_BITS     = (CNT_BITS > lkv_pkg::CAP_BITS) ? CNT_BITS
                                                                 : lkv_pkg::CAP_BITS;

    // Request register
    logic                    req_valid_reg, req_valid_next;
    lkv_pkg::cmd_t           req_cmd_reg;
    logic [KEY_BITS-1:0]     req_key_reg;
    logic [DATA_BITS-1:0]    req_data_reg;

    // Configuration and occupancy
    logic [lkv_pkg::CAP_BITS-1:0] cap_reg, cap_next;
    logic [CNT_BITS-1:0]          occ_reg, occ_next;
    logic [CMP_BITS-1:0]          cap_wide;
    logic [CNT_BITS-1:0]          eff_cap;

    // Result register
    logic                    m_valid_reg, m_valid_next;
    logic                    m_hit_reg;
    logic [DATA_BITS-1:0]    m_data_reg;

    // Cell row
    lkv_pkg::cell_ctrl_t     ctrl;
    logic [MAX_ENTRIES:0]    free_chain;
    logic [MAX_ENTRIES-1:0]  match_vec, take_vec, valid_vec;
    logic [RANK_BITS-1:0]    rank_arr [MAX_ENTRIES];
    logic [DATA_BITS-1:0]    data_arr [MAX_ENTRIES];
    logic [RANK_BITS-1:0]    hit_rank;
    logic [DATA_BITS-1:0]    hit_data;
    logic [RANK_BITS-1:0]    evict_rank;
    logic [CNT_BITS-1:0]     occ_less;
    logic                    out_free;
    logic                    done;

    // Handshake
    assign out_free = !m_valid_reg || m_tready;
    assign done     = req_valid_reg && ((req_cmd_reg == lkv_pkg::CMD_PUT) || out_free);
    assign s_tready = !req_valid_reg || done;

    // Effective capacity clamp
    assign cap_wide = CMP_BITS'(cap_reg);
    always_comb begin
        if (cap_wide == '0) begin
            eff_cap = CNT_BITS'(1);
        end else if (cap_wide > CMP_BITS'(MAX_ENTRIES)) begin
            eff_cap = CNT_BITS'(MAX_ENTRIES);
        end else begin
            eff_cap = CNT_BITS'(cap_wide);
        end
    end

    // Gather the hit entry's rank and data
    always_comb begin
        hit_rank = '0;
        hit_data = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (match_vec[i]) begin
                hit_rank = hit_rank | rank_arr[i];
                hit_data = hit_data | data_arr[i];
            end
        end
    end

    assign occ_less   = occ_reg - 1'b1;
    assign evict_rank = RANK_BITS'(occ_less);

    // Broadcast control
    always_comb begin
        ctrl.update  = done;
        ctrl.clear   = cfg_wr_en;
        ctrl.hit_any = |match_vec;
        ctrl.put     = (req_cmd_reg == lkv_pkg::CMD_PUT);
        ctrl.insert  = ctrl.put && !ctrl.hit_any;
        ctrl.full    = (occ_reg >= eff_cap);
    end

    assign free_chain[0] = 1'b0;

    genvar g;
    generate
        for (g = 0; g < MAX_ENTRIES; g++) begin : g_cell
            lkv_cell #(
                .KEY_BITS  (KEY_BITS),
                .DATA_BITS (DATA_BITS),
                .RANK_BITS (RANK_BITS)
            ) u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctrl       (ctrl),
                .req_key    (req_key_reg),
                .req_data   (req_data_reg),
                .hit_rank   (hit_rank),
                .evict_rank (evict_rank),
                .free_in    (free_chain[g]),
                .free_out   (free_chain[g+1]),
                .match      (match_vec[g]),
                .take       (take_vec[g]),
                .valid      (valid_vec[g]),
                .rank       (rank_arr[g]),
                .data       (data_arr[g])
            );
        end
    endgenerate

    // Control next state
    always_comb begin
        req_valid_next = req_valid_reg;
        if (s_tvalid && s_tready) begin
            req_valid_next = 1'b1;
        end else if (done) begin
            req_valid_next = 1'b0;
        end

        cap_next = cap_reg;
        occ_next = occ_reg;
        if (cfg_wr_en) begin
            cap_next = cfg_wr_data;
            occ_next = '0;
        end else if (done && ctrl.insert && !ctrl.full) begin
            occ_next = occ_reg + 1'b1;
        end

        m_valid_next = m_valid_reg;
        if (done && (req_cmd_reg == lkv_pkg::CMD_GET)) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_valid_reg <= 1'b0;
            cap_reg       <= lkv_pkg::CAP_RESET;
            occ_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            req_valid_reg <= req_valid_next;
            cap_reg       <= cap_next;
            occ_reg       <= occ_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            req_cmd_reg  <= lkv_pkg::cmd_t'(s_tuser);
            req_key_reg  <= s_tdata[KEY_BITS-1:0];
            req_data_reg <= s_tdata[KEY_BITS+DATA_BITS-1:KEY_BITS];
        end
        if (done && (req_cmd_reg == lkv_pkg::CMD_GET)) begin
            m_hit_reg  <= ctrl.hit_any;
            m_data_reg <= ctrl.hit_any ? hit_data : {DATA_BITS{1'b1}};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_hit_reg;
    assign m_tdata  = M_TDATA_BITS'(m_data_reg);

`ifndef SYNTH
    // A retired get always shows a result next cycle
    a_get_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (done && (req_cmd_reg == lkv_pkg::CMD_GET)) |=> m_tvalid)
        else $error("get retired without a result");

    // Occupancy tracks the number of valid cells
    a_occ_count: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(valid_vec) == occ_reg)
        else $error("occupancy count out of step with valid cells");

    // Occupancy never passes the capacity
    a_occ_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= eff_cap)
        else $error("occupancy above capacity");

    // Keys are unique among valid cells
    a_one_match: assert property (@(posedge aclk) disable iff (!aresetn)
        req_valid_reg |-> $onehot0(match_vec))
        else $error("key held in more than one cell");

    // A new key always finds exactly one slot
    a_one_take: assert property (@(posedge aclk) disable iff (!aresetn)
        (done && ctrl.insert && !cfg_wr_en) |-> $onehot(take_vec))
        else $error("insert did not claim exactly one cell");
`endif

endmodule
